/* rtl/core/cwhc_pkg.sv */
// ----------------------------------------------------------------------------
// cwhc_pkg: shared types and constants of the window hill climber
// Command and status bundles between controller and datapath, register
// indexes and the fixed numeric constants of the adjustment.
// ----------------------------------------------------------------------------
package cwhc_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHARD_CAPACITY = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_SIZE    = 1'd1;

  // reset values of the configuration registers
  localparam int unsigned RESET_CAPACITY = 1024;
  localparam int unsigned RESET_SAMPLE   = 10240;

  // hit rate is unsigned Q1.16
  localparam int RATE_W    = 17;
  localparam int RATE_FRAC = 16;

  // |swing| * 20 >= 1.0 in Q1.16 is the same as |swing| >= 3277
  localparam logic [RATE_W-1:0] SWING_MIN = 17'd3277;

  localparam int unsigned DECAY_NUM   = 98;
  localparam int unsigned PROTECT_NUM = 80;
  localparam int unsigned PCT_DEN     = 100;
  localparam int unsigned STEP_FLOOR  = 512;  // 2.0 in Q12.8
  localparam int unsigned STEP_SCALE  = 4;    // capacity/16 in Q12.8 is capacity << 4
  localparam int unsigned STEP_FRAC   = 8;

  typedef struct packed {
    logic accept;      // input item taken this cycle
    logic take_rate;   // rate quotient ready: adjust window, launch decay divide
    logic take_decay;  // decay quotient ready: update step, launch protected divide
    logic emit;        // protected quotient ready: load result register
  } cmd_t;

  typedef struct packed {
    logic sample_done; // the offered item closes a sample period
    logic div_busy;    // rate divider or percent scaler still busy
  } status_t;

endpackage

/* rtl/core/cwhc_div.sv */
// ----------------------------------------------------------------------------
// cwhc_div: iterative restoring divider
// One quotient bit per cycle; the quotient holds until the next start.
// ----------------------------------------------------------------------------
module cwhc_div #(
  parameter int N = 48,
  parameter int D = 33
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         busy,
  output logic [N-1:0] quotient
);

  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     dvd;
  logic [D-1:0]     rem;
  logic [D-1:0]     dsr;
  logic [CNT_W-1:0] cnt;
  logic [D:0]       rem_sh;
  logic             fits;

  assign rem_sh = {rem, dvd[N-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(N);
    end else if (busy) begin
      busy <= cnt != CNT_W'(1);
      cnt  <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      // shift the quotient bit in where the dividend bit left
      dvd <= {dvd[N-2:0], fits};
      rem <= fits ? D'(rem_sh - {1'b0, dsr}) : rem_sh[D-1:0];
    end
  end

  assign quotient = dvd;

endmodule

/* rtl/core/cwhc_ctrl.sv */
// ----------------------------------------------------------------------------
// cwhc_ctrl: sequencer of the window hill climber
// Admits items, runs the three divides of an adjustment in order and owns
// the result valid flag.
// ----------------------------------------------------------------------------
module cwhc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  cwhc_pkg::status_t status,
  output cwhc_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RATE  = 2'd1;
  localparam logic [1:0] ST_DECAY = 2'd2;
  localparam logic [1:0] ST_PROT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = state != ST_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && status.sample_done) state_next = ST_RATE;
      end
      ST_RATE: begin
        if (!status.div_busy) begin
          cmd.take_rate = 1'b1;
          state_next    = ST_DECAY;
        end
      end
      ST_DECAY: begin
        if (!status.div_busy) begin
          cmd.take_decay = 1'b1;
          state_next     = ST_PROT;
        end
      end
      ST_PROT: begin
        if (!status.div_busy && slot_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !status.div_busy)
    else $error("divider busy while sequencer idle");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && status.sample_done |=> state == ST_RATE)
    else $error("closing item did not start an adjustment");

  a_decay_launched: assert property (@(posedge clk) disable iff (rst)
    cmd.take_rate |=> status.div_busy)
    else $error("decay divide not launched");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    state == ST_PROT && !status.div_busy && out_valid && out_stall
    |=> state == ST_PROT && out_valid)
    else $error("new result overran a pending one");

endmodule

/* rtl/core/cwhc_dp.sv */
// ----------------------------------------------------------------------------
// cwhc_dp: datapath of the window hill climber
// Hit and miss counters, configuration, step and window state, the hit-rate
// divider, the percent scaler and the result register.
// ----------------------------------------------------------------------------
module cwhc_dp #(
  parameter int COUNT_WIDTH    = 32,
  parameter int CAPACITY_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cwhc_pkg::cmd_t                      cmd,
  output cwhc_pkg::status_t                   status,
  input  logic                                hit,
  input  logic                                cfg_valid,
  input  logic [cwhc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cwhc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [CAPACITY_WIDTH-1:0]           window_limit,
  output logic [CAPACITY_WIDTH-1:0]           protected_limit,
  output logic [cwhc_pkg::RATE_W-1:0]         sampled_hit_rate
);

  localparam int CNT = COUNT_WIDTH;
  localparam int CW  = CAPACITY_WIDTH;
  localparam int RW  = cwhc_pkg::RATE_W;
  // step magnitude holds max(capacity*16, 512)
  localparam int MW  = (CW + 4 > 10) ? CW + 4 : 10;
  localparam int SW  = MW + 2;
  localparam int CMP_W = (CNT + 1 > cwhc_pkg::CFG_DATA_W) ? CNT + 1 : cwhc_pkg::CFG_DATA_W;
  localparam int DIV_N  = CNT + cwhc_pkg::RATE_FRAC;
  localparam int DIV_D  = CNT + 1;

  // percent scaling: the scaled operand (step*98 or split*80) stays below
  // 2^PY, so floor(y/100) equals (y*PCT_RECIP) >> PCT_SHIFT for every such y
  localparam int PY        = MW + 7;
  localparam int PCT_SHIFT = PY + 7;
  localparam logic [63:0] PCT_RECIP_L =
    ((64'd1 << PCT_SHIFT) + 64'(cwhc_pkg::PCT_DEN) - 64'd1) / 64'(cwhc_pkg::PCT_DEN);
  localparam logic [PY:0] PCT_RECIP = PCT_RECIP_L[PY:0];

  localparam int unsigned RESET_CAP_I = (CW > 10) ? cwhc_pkg::RESET_CAPACITY : 0;
  localparam int unsigned RESET_WIN_I =
    (RESET_CAP_I / cwhc_pkg::PCT_DEN < 1) ? 1 : RESET_CAP_I / cwhc_pkg::PCT_DEN;
  localparam int unsigned RESET_MAG_I =
    ((RESET_CAP_I << cwhc_pkg::STEP_SCALE) < cwhc_pkg::STEP_FLOOR) ?
    cwhc_pkg::STEP_FLOOR : (RESET_CAP_I << cwhc_pkg::STEP_SCALE);

  logic [CW-1:0]                     cap;
  logic [cwhc_pkg::CFG_DATA_W-1:0]   sample_size;
  logic [CNT-1:0]                    hit_count;
  logic [CNT-1:0]                    miss_count;
  logic [RW-1:0]                     prev_rate;
  logic                              step_neg;
  logic [MW-1:0]                     step_mag;
  logic [CW-1:0]                     cur_win;
  logic [RW-1:0]                     rate;
  logic                              neg_hold;
  logic                              rearm_hold;

  logic [CNT-1:0]   hit_next;
  logic [CNT-1:0]   miss_next;
  logic [CNT:0]     total_next;
  logic [RW-1:0]    rate_q;
  logic [RW:0]      swing;
  logic [RW-1:0]    swing_mag;
  logic             swing_neg;
  logic             neg_now;
  logic             rearm_now;
  logic [MW-1:0]    init_mag;
  logic signed [SW-1:0] win_s, move_s, cap_s, hi_s, nwin_s, clamp_s;

  logic             div_start;
  logic [DIV_N-1:0] div_dividend;
  logic [DIV_D-1:0] div_divisor;
  logic             div_busy;
  logic [DIV_N-1:0] div_quot;

  logic             pct_start;
  logic [PY-1:0]    pct_num_in;
  logic [PY-1:0]    pct_num;
  logic             pct_busy;
  logic [2*PY:0]    pct_prod;
  logic [MW-1:0]    pct_quot;

  // saturating counters and the end-of-sample test
  always_comb begin
    hit_next   = hit_count;
    miss_next  = miss_count;
    if (hit) begin
      if (hit_count != '1) hit_next = hit_count + CNT'(1);
    end else begin
      if (miss_count != '1) miss_next = miss_count + CNT'(1);
    end
    total_next = {1'b0, hit_next} + {1'b0, miss_next};
  end

  assign status.sample_done = CMP_W'(total_next) >= CMP_W'(sample_size);
  assign status.div_busy    = div_busy || pct_busy;

  // rate swing, direction and step re-arm
  assign rate_q    = div_quot[RW-1:0];
  assign swing     = {1'b0, rate_q} - {1'b0, prev_rate};
  assign swing_neg = swing[RW];
  assign swing_mag = swing_neg ? RW'(-swing) : swing[RW-1:0];
  assign rearm_now = swing_mag >= cwhc_pkg::SWING_MIN;
  assign neg_now   = (step_mag != '0) && (step_neg ^ swing_neg);

  assign init_mag = ((MW'(cap) << cwhc_pkg::STEP_SCALE) < MW'(cwhc_pkg::STEP_FLOOR)) ?
                    MW'(cwhc_pkg::STEP_FLOOR) : (MW'(cap) << cwhc_pkg::STEP_SCALE);

  // window move by whole blocks, clamped to [1, max(capacity-2, 1)]
  always_comb begin
    win_s  = $signed({{(SW - CW){1'b0}}, cur_win});
    move_s = $signed({2'b00, step_mag >> cwhc_pkg::STEP_FRAC});
    cap_s  = $signed({{(SW - CW){1'b0}}, cap});
    hi_s   = cap_s - $signed(SW'(2));
    if (hi_s < $signed(SW'(1))) hi_s = $signed(SW'(1));
    nwin_s = neg_now ? win_s - move_s : win_s + move_s;
    clamp_s = nwin_s;
    if (clamp_s > hi_s) clamp_s = hi_s;
    if (clamp_s < $signed(SW'(1))) clamp_s = $signed(SW'(1));
  end

  // hit rate: hits in Q1.16 over the closing total
  assign div_start    = cmd.accept && status.sample_done;
  assign div_dividend = DIV_N'(hit_next) << cwhc_pkg::RATE_FRAC;
  assign div_divisor  = total_next;

  cwhc_div #(
    .N(DIV_N),
    .D(DIV_D)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // percent scaler: decay step after the rate, then the protected split
  assign pct_start = cmd.take_rate || cmd.take_decay;

  always_comb begin
    pct_num_in = '0;
    if (cmd.take_rate) begin
      pct_num_in = PY'(step_mag) * PY'(cwhc_pkg::DECAY_NUM);
    end else if (cmd.take_decay && (cap > cur_win)) begin
      pct_num_in = PY'(cap - cur_win) * PY'(cwhc_pkg::PROTECT_NUM);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pct_busy <= 1'b0;
    end else begin
      pct_busy <= pct_start;
    end
  end

  always_ff @(posedge clk) begin
    if (pct_start) pct_num <= pct_num_in;
    if (pct_busy) pct_prod <= pct_num * PCT_RECIP;
  end

  assign pct_quot = pct_prod[PCT_SHIFT +: MW];

  always_ff @(posedge clk) begin
    if (rst) begin
      cap         <= CW'(RESET_CAP_I);
      sample_size <= cwhc_pkg::CFG_DATA_W'(cwhc_pkg::RESET_SAMPLE);
      hit_count   <= '0;
      miss_count  <= '0;
      prev_rate   <= '0;
      step_neg    <= 1'b0;
      step_mag    <= MW'(RESET_MAG_I);
      cur_win     <= CW'(RESET_WIN_I);
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          cwhc_pkg::CFG_SHARD_CAPACITY: cap         <= cfg_data[CW-1:0];
          cwhc_pkg::CFG_SAMPLE_SIZE:    sample_size <= cfg_data;
        endcase
      end
      if (cmd.accept) begin
        if (status.sample_done) begin
          hit_count  <= '0;
          miss_count <= '0;
        end else begin
          hit_count  <= hit_next;
          miss_count <= miss_next;
        end
      end
      if (cmd.take_rate) begin
        prev_rate <= rate_q;
        cur_win   <= clamp_s[CW-1:0];
      end
      if (cmd.take_decay) begin
        step_neg <= neg_hold;
        step_mag <= rearm_hold ? init_mag : pct_quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_rate) begin
      rate       <= rate_q;
      neg_hold   <= neg_now;
      rearm_hold <= rearm_now;
    end
    if (cmd.emit) begin
      window_limit     <= cur_win;
      protected_limit  <= pct_quot[CW-1:0];
      sampled_hit_rate <= rate;
    end
  end

endmodule

/* rtl/core/cache_window_hill_climber_unit.sv */
// ----------------------------------------------------------------------------
// cache_window_hill_climber_unit: adaptive admission window by hill climbing
// Counts cache hits and misses and, once per sample period, retunes the
// window and protected segment limits.
// ----------------------------------------------------------------------------
// Each input item is one access outcome (hit = 1 on a hit). While idle the
// block takes one item per cycle. The item that brings hits plus misses up to
// sample_size starts an adjustment, and input stalls until its result is emitted.
// A restoring divider that produces one quotient bit per cycle forms the
// Q1.16 hit rate; the sequencer then takes the rate and moves the window,
// and the 0.98 step decay and the 80/100 protected split each pass through
// a reciprocal multiply with a registered operand and a registered product.
// A finished result sits in an output register, so further items are taken
// while it waits; the last step of the next adjustment holds until that
// result is taken. Counters saturate at their full width. Configuration
// writes are always ready; a new shard_capacity feeds step re-arm, clamping
// and the protected split from then on, while step and window derive from
// capacity only at reset.
// ----------------------------------------------------------------------------
module cache_window_hill_climber_unit #(
  parameter int COUNT_WIDTH    = 32,
  parameter int CAPACITY_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // access outcome channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             hit,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [CAPACITY_WIDTH-1:0]        window_limit,
  output logic [CAPACITY_WIDTH-1:0]        protected_limit,
  output logic [cwhc_pkg::RATE_W-1:0]      sampled_hit_rate,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cwhc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cwhc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cwhc_pkg::cmd_t    cmd;
  cwhc_pkg::status_t status;

  // registers are plain flops: accept a write in any cycle
  assign cfg_ready = 1'b1;

  // sequence the adjustment: admit, divide rate, decay step, split, emit
  cwhc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // hold counters, step, window and the result register
  cwhc_dp #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .CAPACITY_WIDTH (CAPACITY_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .hit              (hit),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .window_limit     (window_limit),
    .protected_limit  (protected_limit),
    .sampled_hit_rate (sampled_hit_rate)
  );

endmodule
